@@ design/life_automaton_grid_top_macros.svh @@
// assertion macros shared by the checker
`ifndef LIFE_AUTOMATON_GRID_TOP_MACROS_SVH
`define LIFE_AUTOMATON_GRID_TOP_MACROS_SVH

// checked only outside reset
`define LG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked through reset as well
`define LG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/lifegrid_pkg.sv @@
package lifegrid_pkg;

  localparam int ROWS  = 128;
  localparam int COLS  = 128;
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);

  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_TOGGLE = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_STEP   = 3'd4;

  localparam logic [3:0] SURVIVE_LOW  = 4'd2;
  localparam logic [3:0] SURVIVE_HIGH = 4'd3;
  localparam logic [3:0] BIRTH_COUNT  = 4'd3;

  typedef logic [COLS-1:0] row_t;

  typedef struct packed {
    logic [2:0] op;
    logic [6:0] cell_row;
    logic [6:0] cell_col;
    logic       write_value;
  } req_t;

  typedef struct packed {
    logic       read_value;
    logic [2:0] done_op;
  } rsp_t;

  typedef struct packed {
    logic             clr;
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
  } mem_req_t;

endpackage

@@ design/life_automaton_grid_top.sv @@
// flow: cell write and toggle fetch the row and write it back in S_CELL_WR, a read only fetches it;
// clear and unused codes go straight to S_DONE; a generation step passes S_LOAD and S_SWEEP;
// every op then waits in S_DONE until the output register is free. throughput: one word at a time;
// a step sweeps the row memory once, one row per cycle through the shared row update unit
// reset: synchronous, clears the whole grid at once through per-row valid bits
module life_automaton_grid_top import lifegrid_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_CELL_WR = 5'b00010,
    S_LOAD    = 5'b00100,
    S_SWEEP   = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  state_t           state, state_next;
  req_t             item;
  logic             res_bit;
  logic [ROW_W-1:0] r;
  row_t             above_row_copy;
  row_t             current_row_copy;

  mem_req_t         ctl;
  row_t             wr_data;
  row_t             rd_data;
  row_t             rule_out;
  row_t             below;
  row_t             cell_row_mod;

  logic             accept;
  logic             in_grid;
  logic [COL_W-1:0] col_idx;
  logic             last_row;
  logic [ROW_W:0]   r_ahead;
  logic             slot_free;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign slot_free = !rsp_valid || !rsp_stall;

  assign in_grid = (32'(item.cell_row) < 32'(ROWS)) && (32'(item.cell_col) < 32'(COLS));
  assign col_idx = COL_W'(item.cell_col);

  assign last_row = (r == ROW_W'(ROWS - 1));
  assign r_ahead  = {1'b0, r} + (ROW_W + 1)'(2);
  assign below    = last_row ? '0 : rd_data;

  lifegrid_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  lifegrid_rule u_rule (
    .above    (above_row_copy),
    .cur      (current_row_copy),
    .below    (below),
    .next_row (rule_out)
  );

  always_comb begin
    cell_row_mod = rd_data;
    if (item.op == OP_WRITE) begin
      cell_row_mod[col_idx] = item.write_value;
    end else begin
      cell_row_mod[col_idx] = ~rd_data[col_idx];
    end
  end

  always_comb begin
    ctl        = '0;
    wr_data    = rule_out;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.op) inside
            OP_WRITE, OP_TOGGLE, OP_READ: begin
              ctl.rd_en   = 1'b1;
              ctl.rd_addr = ROW_W'(req.cell_row);
              state_next  = S_CELL_WR;
            end
            OP_STEP: begin
              ctl.rd_en   = 1'b1;
              ctl.rd_addr = '0;
              state_next  = S_LOAD;
            end
            OP_CLEAR: begin
              ctl.clr    = 1'b1;
              state_next = S_DONE;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_CELL_WR: begin
        ctl.wr_en   = in_grid && ((item.op == OP_WRITE) || (item.op == OP_TOGGLE));
        ctl.wr_addr = ROW_W'(item.cell_row);
        wr_data     = cell_row_mod;
        state_next  = S_DONE;
      end
      S_LOAD: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_addr = ROW_W'(1);
        state_next  = S_SWEEP;
      end
      S_SWEEP: begin
        // rewrite row r while fetching row r+2
        ctl.wr_en   = 1'b1;
        ctl.wr_addr = r;
        ctl.rd_en   = (32'(r_ahead) < 32'(ROWS));
        ctl.rd_addr = r_ahead[ROW_W-1:0];
        if (last_row) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item    <= req;
      res_bit <= 1'b0;
    end
    if (state == S_CELL_WR) begin
      res_bit <= (item.op == OP_READ) && in_grid && rd_data[col_idx];
    end
    if (state == S_LOAD) begin
      current_row_copy <= rd_data;
      above_row_copy   <= '0;
      r                <= '0;
    end
    if (state == S_SWEEP) begin
      above_row_copy   <= current_row_copy;
      current_row_copy <= below;
      r                <= r + ROW_W'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && slot_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && slot_free) begin
      rsp.read_value <= res_bit;
      rsp.done_op    <= item.op;
    end
  end

endmodule

@@ design/lifegrid_mem.sv @@
module lifegrid_mem import lifegrid_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mem_req_t ctl,
  input  row_t     wr_data,
  output row_t     rd_data
);

  row_t            mem [ROWS];
  logic [ROWS-1:0] row_valid;
  row_t            q;
  logic            q_valid;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      q <= mem[ctl.rd_addr];
    end
  end

  // rows never written since reset or clear read as dead
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      q_valid   <= 1'b0;
    end else begin
      if (ctl.clr) begin
        row_valid <= '0;
      end else if (ctl.wr_en) begin
        row_valid[ctl.wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        q_valid <= row_valid[ctl.rd_addr];
      end
    end
  end

  assign rd_data = q_valid ? q : '0;

endmodule

@@ design/lifegrid_rule.sv @@
module lifegrid_rule import lifegrid_pkg::*; (
  input  row_t above,
  input  row_t cur,
  input  row_t below,
  output row_t next_row
);

  logic [COLS+1:0] a_ext;
  logic [COLS+1:0] c_ext;
  logic [COLS+1:0] b_ext;

  // zero pad on both sides so edge cells see dead neighbors
  assign a_ext = {1'b0, above, 1'b0};
  assign c_ext = {1'b0, cur, 1'b0};
  assign b_ext = {1'b0, below, 1'b0};

  always_comb begin
    logic [3:0] cnt;
    next_row = '0;
    for (int c = 0; c < COLS; c++) begin
      cnt = 4'(a_ext[c]) + 4'(a_ext[c+1]) + 4'(a_ext[c+2])
          + 4'(c_ext[c]) + 4'(c_ext[c+2])
          + 4'(b_ext[c]) + 4'(b_ext[c+1]) + 4'(b_ext[c+2]);
      if (cur[c]) begin
        next_row[c] = (cnt >= SURVIVE_LOW) && (cnt <= SURVIVE_HIGH);
      end else begin
        next_row[c] = (cnt == BIRTH_COUNT);
      end
    end
  end

endmodule

@@ design/lifegrid_chk.sv @@
`include "life_automaton_grid_top_macros.svh"

module lifegrid_chk import lifegrid_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  `LG_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "word changed")
  `LG_ASSERT(a_busy, req_valid && !req_stall |=> req_stall, "input open after accept")
  `LG_ASSERT(a_read_bit, rsp_valid |-> (rsp.done_op == OP_READ) || !rsp.read_value, "read bit set")
  `LG_ASSERT_RST(a_reset_empty, rst |=> !rsp_valid && !req_stall, "not empty after reset")

endmodule

bind life_automaton_grid_top lifegrid_chk u_chk (.*);

@@ tb/sv/tb_top.sv @@
module tb_top;
  import lifegrid_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // op codes that the block does not define
  localparam logic [2:0] OP_RSVD_A = 3'd5;
  localparam logic [2:0] OP_RSVD_B = 3'd6;
  localparam logic [2:0] OP_RSVD_C = 3'd7;

  localparam int RANDOM_PER_PHASE = 380;
  localparam int DRAIN_CYCLES     = ROWS + 8;
  localparam int WATCHDOG_LIMIT   = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b1;
  rsp_t rsp;

  req_t pending_words[$];
  rsp_t expected_rsp[$];
  row_t life_grid [ROWS];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int stuck_cycles = 0;

  life_automaton_grid_top dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // all cells update at once from the previous generation; off-grid cells are dead
  function automatic void advance_generation();
    row_t prev_grid [ROWS];
    int live_nb;
    int rr;
    int cc;
    prev_grid = life_grid;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        live_nb = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < ROWS && cc >= 0 && cc < COLS) begin
              live_nb += prev_grid[rr][cc];
            end
          end
        end
        if (prev_grid[r][c]) begin
          life_grid[r][c] = (live_nb >= SURVIVE_LOW) && (live_nb <= SURVIVE_HIGH);
        end else begin
          life_grid[r][c] = (live_nb == BIRTH_COUNT);
        end
      end
    end
  endfunction

  function automatic rsp_t predict_word(input req_t w);
    rsp_t res;
    logic on_grid;
    on_grid = (w.cell_row < ROWS) && (w.cell_col < COLS);
    res = '0;
    res.done_op = w.op;
    case (w.op)
      OP_WRITE: begin
        if (on_grid) life_grid[w.cell_row][w.cell_col] = w.write_value;
      end
      OP_TOGGLE: begin
        if (on_grid) life_grid[w.cell_row][w.cell_col] = ~life_grid[w.cell_row][w.cell_col];
      end
      OP_CLEAR: begin
        for (int r = 0; r < ROWS; r++) life_grid[r] = '0;
      end
      OP_READ: begin
        if (on_grid) res.read_value = life_grid[w.cell_row][w.cell_col];
      end
      OP_STEP: begin
        advance_generation();
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic req_t make_word(input logic [2:0] op, input int row, input int col,
                                     input logic wv);
    req_t w;
    w.op = op;
    w.cell_row = 7'(row);
    w.cell_col = 7'(col);
    w.write_value = wv;
    return w;
  endfunction

  task automatic check_word(input rsp_t got);
    rsp_t want;
    if (expected_rsp.size() == 0) begin
      report_mismatch($sformatf("unexpected word op=%0d read=%0d", got.done_op, got.read_value));
    end else begin
      want = expected_rsp.pop_front();
      if (got.done_op !== want.done_op) begin
        report_mismatch($sformatf("done_op got %0d want %0d", got.done_op, want.done_op));
      end
      if (got.read_value !== want.read_value) begin
        report_mismatch($sformatf("read_value got %0b want %0b (op %0d)",
                                  got.read_value, want.read_value, want.done_op));
      end
    end
  endtask

  // mostly edits and reads around a hot spot, so that patterns form and evolve
  task automatic queue_random(input int n_words);
    req_t w;
    int hot_row;
    int hot_col;
    int pick;
    hot_row = $urandom_range(0, ROWS - 1);
    hot_col = $urandom_range(0, COLS - 1);
    for (int i = 0; i < n_words; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        pick = $urandom_range(0, 3);
        hot_row = (pick == 0) ? 0 : (pick == 1) ? ROWS - 6 : $urandom_range(0, ROWS - 1);
        pick = $urandom_range(0, 3);
        hot_col = (pick == 0) ? 0 : (pick == 1) ? COLS - 6 : $urandom_range(0, COLS - 1);
      end
      w.cell_row = 7'($urandom_range(0, 127));
      w.cell_col = 7'($urandom_range(0, 127));
      w.write_value = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 30) w.op = OP_WRITE;
      else if (pick < 44) w.op = OP_TOGGLE;
      else if (pick < 80) w.op = OP_READ;
      else if (pick < 89) w.op = OP_STEP;
      else if (pick < 91) w.op = OP_CLEAR;
      else w.op = 3'($urandom_range(OP_RSVD_A, OP_RSVD_C));
      if ((w.op == OP_WRITE || w.op == OP_TOGGLE || w.op == OP_READ)
          && $urandom_range(0, 3) != 0) begin
        w.cell_row = 7'(hot_row + $urandom_range(0, 5));
        w.cell_col = 7'(hot_col + $urandom_range(0, 5));
        if (w.op == OP_WRITE && $urandom_range(0, 9) < 7) w.write_value = 1'b1;
      end
      pending_words.push_back(w);
    end
  endtask

  task automatic queue_directed();
    pending_words.push_back(make_word(OP_WRITE, 0, 0, 1'b1));
    pending_words.push_back(make_word(OP_WRITE, 127, 127, 1'b1));
    pending_words.push_back(make_word(OP_WRITE, 0, 127, 1'b1));
    pending_words.push_back(make_word(OP_TOGGLE, 127, 0, 1'b0));
    pending_words.push_back(make_word(OP_READ, 0, 0, 1'b1));
    pending_words.push_back(make_word(OP_READ, 127, 127, 1'b0));
    pending_words.push_back(make_word(OP_READ, 127, 0, 1'b1));
    pending_words.push_back(make_word(OP_READ, 64, 64, 1'b0));
    // lone cells die; address fields of a step are ignored
    pending_words.push_back(make_word(OP_STEP, 127, 127, 1'b1));
    pending_words.push_back(make_word(OP_READ, 0, 0, 1'b0));
    // blinker against the top edge
    pending_words.push_back(make_word(OP_WRITE, 0, 60, 1'b1));
    pending_words.push_back(make_word(OP_WRITE, 0, 61, 1'b1));
    pending_words.push_back(make_word(OP_WRITE, 0, 62, 1'b1));
    // three cells in the bottom right corner grow into a block
    pending_words.push_back(make_word(OP_WRITE, 126, 126, 1'b1));
    pending_words.push_back(make_word(OP_WRITE, 126, 127, 1'b1));
    pending_words.push_back(make_word(OP_WRITE, 127, 126, 1'b1));
    pending_words.push_back(make_word(OP_STEP, 0, 0, 1'b0));
    pending_words.push_back(make_word(OP_READ, 1, 61, 1'b0));
    pending_words.push_back(make_word(OP_READ, 127, 127, 1'b0));
    pending_words.push_back(make_word(OP_WRITE, 1, 61, 1'b0));
    pending_words.push_back(make_word(OP_CLEAR, 85, 42, 1'b1));
    pending_words.push_back(make_word(OP_READ, 0, 61, 1'b0));
    pending_words.push_back(make_word(OP_RSVD_A, 127, 0, 1'b1));
    pending_words.push_back(make_word(OP_RSVD_B, 0, 127, 1'b0));
    pending_words.push_back(make_word(OP_RSVD_C, 127, 127, 1'b1));
  endtask

  task automatic wait_all_done();
    do begin
      @(negedge clk);
    end while (pending_words.size() != 0 || req_valid || expected_rsp.size() != 0);
  endtask

  // driver: a new word is presented only once the previous one was taken
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
    end else begin
      if (req_valid && !req_stall) expected_rsp.push_back(predict_word(req));
      if (!req_valid || !req_stall) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req_valid <= 1'b1;
          req <= pending_words.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b1;
    end else begin
      if (rsp_valid && !rsp_stall) check_word(rsp);
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    for (int r = 0; r < ROWS; r++) life_grid[r] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    send_idle_pct = 34;
    recv_idle_pct = 55;
    queue_directed();
    queue_random(RANDOM_PER_PHASE);
    // sender holds off until every word of the phase is back
    wait_all_done();

    send_idle_pct = 55;
    recv_idle_pct = 34;
    queue_random(RANDOM_PER_PHASE);
    wait_all_done();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(RANDOM_PER_PHASE);
    wait_all_done();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_rsp.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
